// ===== rtl/core/dia_pkg.sv =====
package dia_pkg;

  // Default sizing of the allocator.
  localparam int unsigned MAX_SLOTS_DEF   = 4096;
  localparam int unsigned FREE_RANGES_DEF = 16;

  // Request kinds carried on the input tuser bit.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status carried on the output tuser bits.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_LIST_FULL = 2'd2
  } status_t;

  // Per-cell control for one evaluation cycle.
  typedef struct packed {
    logic in_use;    // cell holds a live range
    logic free_go;   // a valid free is committed this cycle
    logic alloc_go;  // this cell is the last range and an allocate commits
    logic app_go;    // this cell receives the appended one-slot range
  } cell_ctl_t;

endpackage

// ===== rtl/core/dia_cell.sv =====
module dia_cell #(
  parameter int unsigned IW = 12,
  parameter int unsigned CW = 13
) (
  input  logic              clk,
  input  dia_pkg::cell_ctl_t ctl,
  input  logic [IW-1:0]     idx,
  input  logic              found_in,
  output logic              found_out,
  output logic [IW-1:0]     start_o,
  output logic              short_o
);

  logic [IW-1:0] start_r, start_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [IW+1:0] end_sum;
  logic          end_hit;
  logic          beg_hit;
  logic          take;

  // A range matches if it ends right below the freed slot or starts right above it.
  assign end_sum   = {2'b00, start_r} + {1'b0, len_r};
  assign end_hit   = ctl.in_use && (end_sum == {2'b00, idx});
  assign beg_hit   = ctl.in_use && (start_r != '0) && ((start_r - IW'(1)) == idx);
  assign take      = ctl.free_go && (end_hit || beg_hit) && !found_in;
  assign found_out = found_in || end_hit || beg_hit;

  assign start_o = start_r;
  assign short_o = (len_r <= CW'(1));

  always_comb begin
    start_nxt = start_r;
    len_nxt   = len_r;
    if (take) begin
      len_nxt = len_r + CW'(1);
      if (!end_hit) begin
        start_nxt = idx;
      end
    end else if (ctl.app_go) begin
      start_nxt = idx;
      len_nxt   = CW'(1);
    end else if (ctl.alloc_go && !short_o) begin
      start_nxt = start_r + IW'(1);
      len_nxt   = len_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    len_r   <= len_nxt;
  end

endmodule

// ===== rtl/core/descriptor_index_allocator.sv =====
// Slot index allocator with a free range list.
//
// Requests arrive as beats on the in_ channel: in_tuser selects allocate (0)
// or free (1), in_tdata carries the slot being returned on a free. Every
// request produces exactly one result beat on the out_ channel: the slot
// handed out, a status code on out_tuser and the live slot count.
// The cfg_ channel writes the capacity register; write it only while idle.
//
// Freed slots are held as ranges in a row of identical cells. A free is
// broadcast to all cells and a match token ripples down the row so the first
// matching range grows; without a match the range is appended after the last
// used cell, or ST_LIST_FULL results if no cell is free. An allocate takes
// the lowest slot of the last used range, or the bump pointer when no range exists.
//
// A request is held in the request register from its accept edge and commits
// into the output register once the output is free, raising out_tvalid.
// One request is in flight at a time; a new one is taken only after it commits.
// A stalled receiver holds the result; the next request waits in its
// register until the output frees. Reset (rst_n low, synchronous) empties
// the ranges, clears the bump pointer and live count, sets capacity to MAX_SLOTS.
module descriptor_index_allocator #(
  parameter int unsigned MAX_SLOTS   = dia_pkg::MAX_SLOTS_DEF,
  parameter int unsigned FREE_RANGES = dia_pkg::FREE_RANGES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // Request channel. in_tdata: free_index. in_tuser: req_type.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((($clog2(MAX_SLOTS))+7)/8)*8-1:0] in_tdata,
  input  logic                                   in_tuser,
  // Result channel. out_tdata: slot_index, then live_count. out_tuser: status.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((2*$clog2(MAX_SLOTS)+1+7)/8)*8-1:0] out_tdata,
  output logic [1:0]                             out_tuser,
  // Capacity register write channel.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [$clog2(MAX_SLOTS):0]             cfg_data
);

  localparam int unsigned IW  = $clog2(MAX_SLOTS);
  localparam int unsigned CW  = IW + 1;
  localparam int unsigned RW  = $clog2(FREE_RANGES + 1);
  localparam int unsigned CIW = (FREE_RANGES > 1) ? $clog2(FREE_RANGES) : 1;
  localparam int unsigned ODW = ((IW + CW + 7) / 8) * 8;
  localparam logic [CW-1:0] CAP_MAX = CW'(MAX_SLOTS);

  // Request register and control state.
  logic          busy_r;
  logic          req_r;
  logic [IW-1:0] idx_r;
  logic [RW-1:0] used_r, used_nxt;
  logic [CW-1:0] bump_r, bump_nxt;
  logic [CW-1:0] live_r, live_nxt;
  logic [CW-1:0] cap_r;

  // Output register.
  logic                out_valid_r;
  logic [IW-1:0]       out_slot_r, slot_nxt;
  dia_pkg::status_t    out_status_r, status_nxt;
  logic [CW-1:0]       out_live_r;

  logic          go;
  logic          accept;
  logic [CW-1:0] cap_eff;
  logic [RW-1:0] last_u;
  logic [CIW-1:0] last_idx;
  logic          full;
  logic          free_valid;
  logic          any_hit;

  dia_pkg::cell_ctl_t ctl [FREE_RANGES];
  logic [FREE_RANGES:0] found;
  logic [IW-1:0]  cell_start [FREE_RANGES];
  logic [FREE_RANGES-1:0] cell_short;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !busy_r;
  assign go        = busy_r && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  assign cap_eff    = (cap_r > CAP_MAX) ? CAP_MAX : cap_r;
  assign last_u     = used_r - RW'(1);
  assign last_idx   = last_u[CIW-1:0];
  assign full       = (used_r >= RW'(FREE_RANGES));
  assign free_valid = ({1'b0, idx_r} < bump_r);
  assign any_hit    = found[FREE_RANGES];

  // Per-cell control decoded from the range count.
  always_comb begin
    for (int i = 0; i < FREE_RANGES; i++) begin
      ctl[i].in_use   = (RW'(i) < used_r);
      ctl[i].free_go  = go && (req_r == dia_pkg::REQ_FREE) && free_valid;
      ctl[i].alloc_go = go && (req_r == dia_pkg::REQ_ALLOC) && (used_r != '0) &&
                        (RW'(i) == last_u);
      ctl[i].app_go   = go && (req_r == dia_pkg::REQ_FREE) && free_valid &&
                        !any_hit && !full && (RW'(i) == used_r);
    end
  end

  assign found[0] = 1'b0;

  for (genvar g = 0; g < FREE_RANGES; g++) begin : g_cell
    dia_cell #(
      .IW(IW),
      .CW(CW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl[g]),
      .idx      (idx_r),
      .found_in (found[g]),
      .found_out(found[g+1]),
      .start_o  (cell_start[g]),
      .short_o  (cell_short[g])
    );
  end

  // Bookkeeping for the committed request.
  always_comb begin
    used_nxt   = used_r;
    bump_nxt   = bump_r;
    live_nxt   = live_r;
    slot_nxt   = '0;
    status_nxt = dia_pkg::ST_OK;
    if (req_r == dia_pkg::REQ_FREE) begin
      if (free_valid) begin
        if (!any_hit && full) begin
          status_nxt = dia_pkg::ST_LIST_FULL;
        end else begin
          if (!any_hit) begin
            used_nxt = used_r + RW'(1);
          end
          if (live_r != '0) begin
            live_nxt = live_r - CW'(1);
          end
        end
      end
    end else begin
      if (used_r != '0) begin
        slot_nxt = cell_start[last_idx];
        if (cell_short[last_idx]) begin
          used_nxt = last_u;
        end
        if (live_r != '1) begin
          live_nxt = live_r + CW'(1);
        end
      end else if (bump_r >= cap_eff) begin
        status_nxt = dia_pkg::ST_EXHAUSTED;
      end else begin
        slot_nxt = bump_r[IW-1:0];
        bump_nxt = bump_r + CW'(1);
        if (live_r != '1) begin
          live_nxt = live_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      used_r      <= '0;
      bump_r      <= '0;
      live_r      <= '0;
      cap_r       <= CAP_MAX;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (accept) begin
        busy_r <= 1'b1;
      end else if (go) begin
        busy_r <= 1'b0;
      end
      if (go) begin
        used_r      <= used_nxt;
        bump_r      <= bump_nxt;
        live_r      <= live_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_tuser;
      idx_r <= in_tdata[IW-1:0];
    end
    if (go) begin
      out_slot_r   <= slot_nxt;
      out_status_r <= status_nxt;
      out_live_r   <= live_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(ODW - IW - CW){1'b0}}, out_live_r, out_slot_r};

  // The range count never passes the number of cells.
  a_used_bound : assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= RW'(FREE_RANGES))
    else $error("range count above cell count");

  // The bump pointer never passes the table size.
  a_bump_bound : assert property (@(posedge clk) disable iff (!rst_n)
    bump_r <= CAP_MAX)
    else $error("bump pointer above table size");

  // An exhausted or full result always reports slot zero.
  a_err_slot : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != dia_pkg::ST_OK) |-> (out_slot_r == '0))
    else $error("error result with nonzero slot");

  // Only one request is in flight: an accepted beat blocks the next cycle.
  a_one_flight : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("second request accepted while busy");

endmodule
